// ===== hdl/lrc_pkg.sv =====
// Package for the LRU result cache: codes, widths, FSM states and shared structs.
package lrc_pkg;

  // action codes
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_FILL   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // key, payload, counter and entry-count widths
  localparam int KEY_W = 232;
  localparam int PAY_W = 64;
  localparam int STAT_W = 32;
  localparam int CNT_OUT_W = 13;

  // defaults
  localparam int DEF_CAPACITY = 4096;
  localparam logic [12:0] MAX_ENTRIES_RST = 13'd4096;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HEAD,
    ST_CMP,
    ST_MTF1,
    ST_MTF2,
    ST_EV_CHK,
    ST_EV_HASH,
    ST_EV_HEAD,
    ST_EV_WALK,
    ST_EV_FREE,
    ST_INS_WR,
    ST_DONE
  } lrc_state_t;

  // counter update requests
  typedef struct packed {
    logic clr;
    logic hit;
    logic miss;
    logic evict;
    logic fail;
  } lrc_bump_t;

  // counter values
  typedef struct packed {
    logic [STAT_W-1:0] hit;
    logic [STAT_W-1:0] miss;
    logic [STAT_W-1:0] evict;
    logic [STAT_W-1:0] fail;
  } lrc_stats_t;

endpackage

// ===== hdl/lrc_stats.sv =====
// Saturating hit, miss, eviction and failure counters of the LRU result cache.
module lrc_stats
  import lrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lrc_bump_t  bump,
  output lrc_stats_t stats
);

  lrc_stats_t cnt_r;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] c);
    return (c == '1) ? c : c + STAT_W'(1);
  endfunction

  // counters, cleared by reset or a clear item
  always_ff @(posedge clk) begin
    if (!rst_n || bump.clr) begin
      cnt_r <= '0;
    end else begin
      if (bump.hit)   cnt_r.hit   <= sat_inc(cnt_r.hit);
      if (bump.miss)  cnt_r.miss  <= sat_inc(cnt_r.miss);
      if (bump.evict) cnt_r.evict <= sat_inc(cnt_r.evict);
      if (bump.fail)  cnt_r.fail  <= sat_inc(cnt_r.fail);
    end
  end

  assign stats = cnt_r;

endmodule

// ===== hdl/lru_result_cache.sv =====
// Top level of the LRU result cache: hashed chains, LRU list and sequencer.
//
// Usage: an item (lookup, fill or clear) is taken when start is high and busy
// is low. One result comes back per item on the out_ ports, marked by a
// one-cycle out_valid strobe; the receiver cannot stall it, and the next item
// may be started in the cycle the strobe is high.
// Entries live in synchronous memories with separate read and write ports:
// a key/payload store, a hash-chain link store, a bucket head table and two
// LRU link stores. Keys hash into 2**clog2(CAPACITY) buckets.
// Per item: lookups and fills walk their bucket's hash chain one link at a
//   time until the key is found or the chain ends; a found entry not yet most
//   recent moves to the front of the LRU list; a fill refreshes its payload.
//   A failed fill or unused code ends at once. A new fill evicts the oldest
//   entries while at the limit, unlinking each from its bucket, then inserts.
// Clear and reset: the bucket table is swept, one entry per cycle, over all
// 2**clog2(CAPACITY) buckets (4096 by default) with busy high; a clear item
// then gives its result. The cfg_ port (always ready) writes max_entries;
// the user must write it only while idle (not enforced); reset loads 4096.
module lru_result_cache
  import lrc_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [12:0]           cfg_data,
  // items
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_action,
  input  logic signed [15:0]    in_tx_cell_x,
  input  logic signed [15:0]    in_tx_cell_y,
  input  logic signed [15:0]    in_tx_cell_z,
  input  logic signed [15:0]    in_rx_cell_x,
  input  logic signed [15:0]    in_rx_cell_y,
  input  logic signed [15:0]    in_rx_cell_z,
  input  logic [39:0]           in_carrier_hz,
  input  logic [31:0]           in_time_bucket,
  input  logic [63:0]           in_setup_digest,
  input  logic                  in_fill_good,
  input  logic [63:0]           in_fill_payload,
  // results
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [63:0]           out_result_payload,
  output logic                  out_evicted,
  output logic [12:0]           out_entry_count,
  output logic [31:0]           out_hit_count,
  output logic [31:0]           out_miss_count,
  output logic [31:0]           out_eviction_count,
  output logic [31:0]           out_failure_count
);

  localparam int SW = $clog2(CAPACITY);
  localparam int NB = 2 ** SW;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > 13) ? CW : 13;
  localparam int WORD_W = KEY_W + PAY_W;

  // memories
  logic [WORD_W-1:0] key_mem   [CAPACITY];
  logic [SW:0]       hn_mem    [CAPACITY];
  logic [SW:0]       head_mem  [NB];
  logic [SW-1:0]     newer_mem [CAPACITY];
  logic [SW-1:0]     older_mem [CAPACITY];

  logic [WORD_W-1:0] key_rd;
  logic [SW:0]       hn_rd, head_rd;
  logic [SW-1:0]     newer_rd, older_rd;

  logic [SW-1:0]     key_ra, key_wa, hn_ra, hn_wa, head_ra, head_wa;
  logic [SW-1:0]     newer_ra, newer_wa, older_ra, older_wa;
  logic              key_we, hn_we, head_we, newer_we, older_we;
  logic [WORD_W-1:0] key_wd;
  logic [SW:0]       hn_wd, head_wd;
  logic [SW-1:0]     newer_wd, older_wd;

  // control and datapath registers
  lrc_state_t        state_r, state_nxt;
  logic [KEY_W-1:0]  key_r;
  logic [PAY_W-1:0]  pay_r;
  logic [1:0]        act_r;
  logic [SW-1:0]     h_r, eh_r, cur_r, onext_r;
  logic [SW:0]       ohn_r;
  logic [SW-1:0]     newest_r, oldest_r, fhead_r, sweep_r;
  logic              fvalid_r, clr_pend_r;
  logic [CW-1:0]     held_r, alloc_r;
  logic              hit_r, ev_r, out_valid_r;
  logic [PAY_W-1:0]  res_r;
  logic [12:0]       max_r;

  lrc_bump_t         bump;
  lrc_stats_t        stats;

  logic [KEY_W-1:0]  in_key;
  logic              accept, match, ev_need, use_alloc;
  logic [LW-1:0]     lim_min, lim;
  logic [SW-1:0]     new_slot;

  // XOR fold of the key down to a bucket index
  function automatic logic [SW-1:0] key_hash(input logic [KEY_W-1:0] k);
    logic [SW-1:0] h;
    h = '0;
    for (int b = 0; b < KEY_W; b++) begin
      h[b % SW] = h[b % SW] ^ k[b];
    end
    return h;
  endfunction

  assign in_key = {in_tx_cell_z, in_tx_cell_y, in_tx_cell_x,
                   in_rx_cell_z, in_rx_cell_y, in_rx_cell_x,
                   in_carrier_hz, in_time_bucket, in_setup_digest};

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign match     = (key_rd[WORD_W-1:PAY_W] == key_r);

  // effective entry limit: zero acts as one, capped at capacity
  always_comb begin
    lim_min = (max_r == '0) ? LW'(1) : LW'(max_r);
    lim     = (lim_min > LW'(CAPACITY)) ? LW'(CAPACITY) : lim_min;
  end
  assign ev_need   = (LW'(held_r) >= lim) && (held_r != '0);
  assign use_alloc = (alloc_r < CW'(CAPACITY));
  assign new_slot  = use_alloc ? alloc_r[SW-1:0] : fhead_r;

  // synchronous memories
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_rd <= key_mem[key_ra];
  end
  always_ff @(posedge clk) begin
    if (hn_we) hn_mem[hn_wa] <= hn_wd;
    hn_rd <= hn_mem[hn_ra];
  end
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    newer_rd <= newer_mem[newer_ra];
  end
  always_ff @(posedge clk) begin
    if (older_we) older_mem[older_wa] <= older_wd;
    older_rd <= older_mem[older_ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (sweep_r == '1) state_nxt = clr_pend_r ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_LOOKUP: state_nxt = ST_HEAD;
            ACT_FILL:   state_nxt = in_fill_good ? ST_HEAD : ST_DONE;
            ACT_CLEAR:  state_nxt = ST_SWEEP;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_HEAD: begin
        if (head_rd[SW])              state_nxt = ST_CMP;
        else if (act_r == ACT_LOOKUP) state_nxt = ST_DONE;
        else                          state_nxt = ST_EV_CHK;
      end
      ST_CMP: begin
        if (match)                    state_nxt = (cur_r == newest_r) ? ST_DONE : ST_MTF1;
        else if (hn_rd[SW])           state_nxt = ST_CMP;
        else if (act_r == ACT_LOOKUP) state_nxt = ST_DONE;
        else                          state_nxt = ST_EV_CHK;
      end
      ST_MTF1:    state_nxt = ST_MTF2;
      ST_MTF2:    state_nxt = ST_DONE;
      ST_EV_CHK:  state_nxt = ev_need ? ST_EV_HASH : ST_INS_WR;
      ST_EV_HASH: state_nxt = ST_EV_HEAD;
      ST_EV_HEAD: state_nxt = (head_rd[SW-1:0] == oldest_r) ? ST_EV_FREE : ST_EV_WALK;
      ST_EV_WALK: state_nxt = (hn_rd[SW-1:0] == oldest_r) ? ST_EV_FREE : ST_EV_WALK;
      ST_EV_FREE: state_nxt = ST_EV_CHK;
      ST_INS_WR:  state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // memory accesses and counter requests
  always_comb begin
    key_ra   = cur_r;
    hn_ra    = cur_r;
    head_ra  = h_r;
    newer_ra = cur_r;
    older_ra = cur_r;
    key_we   = 1'b0;  key_wa   = cur_r;    key_wd   = {key_r, pay_r};
    hn_we    = 1'b0;  hn_wa    = cur_r;    hn_wd    = ohn_r;
    head_we  = 1'b0;  head_wa  = h_r;      head_wd  = ohn_r;
    newer_we = 1'b0;  newer_wa = newest_r; newer_wd = cur_r;
    older_we = 1'b0;  older_wa = cur_r;    older_wd = newest_r;
    bump     = '0;
    unique case (state_r)
      ST_SWEEP: begin
        head_we = 1'b1;
        head_wa = sweep_r;
        head_wd = '0;
      end
      ST_IDLE: begin
        head_ra  = key_hash(in_key);
        bump.clr = accept && (in_action == ACT_CLEAR);
        bump.fail = accept && (in_action == ACT_FILL) && !in_fill_good;
      end
      ST_HEAD: begin
        key_ra = head_rd[SW-1:0];
        hn_ra  = head_rd[SW-1:0];
        bump.miss = !head_rd[SW] && (act_r == ACT_LOOKUP);
      end
      ST_CMP: begin
        key_ra = hn_rd[SW-1:0];
        hn_ra  = hn_rd[SW-1:0];
        // refresh the payload of a present key
        key_we = match && (act_r == ACT_FILL);
        bump.hit  = match && (act_r == ACT_LOOKUP);
        bump.miss = !match && !hn_rd[SW] && (act_r == ACT_LOOKUP);
      end
      ST_MTF1: begin
        // splice the entry out of the LRU list
        newer_we = (cur_r != oldest_r);
        newer_wa = older_rd;
        newer_wd = newer_rd;
        older_we = 1'b1;
        older_wa = newer_rd;
        older_wd = older_rd;
      end
      ST_MTF2: begin
        // and put it back as most recent
        older_we = 1'b1;
        newer_we = 1'b1;
      end
      ST_EV_CHK: begin
        key_ra   = oldest_r;
        newer_ra = oldest_r;
        hn_ra    = ev_need ? oldest_r : fhead_r;
      end
      ST_EV_HASH: begin
        head_ra = key_hash(key_rd[WORD_W-1:PAY_W]);
      end
      ST_EV_HEAD: begin
        hn_ra   = head_rd[SW-1:0];
        head_we = (head_rd[SW-1:0] == oldest_r);
        head_wa = eh_r;
      end
      ST_EV_WALK: begin
        hn_ra = hn_rd[SW-1:0];
        hn_we = (hn_rd[SW-1:0] == oldest_r);
      end
      ST_EV_FREE: begin
        // freed slot goes on the free list
        hn_we = 1'b1;
        hn_wa = oldest_r;
        hn_wd = {fvalid_r, fhead_r};
        bump.evict = 1'b1;
      end
      ST_INS_WR: begin
        key_we   = 1'b1;
        key_wa   = new_slot;
        hn_we    = 1'b1;
        hn_wa    = new_slot;
        hn_wd    = head_rd;
        head_we  = 1'b1;
        head_wd  = {1'b1, new_slot};
        older_we = (held_r != '0);
        older_wa = new_slot;
        newer_we = (held_r != '0);
        newer_wd = new_slot;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      clr_pend_r  <= 1'b0;
      held_r      <= '0;
      alloc_r     <= '0;
      fvalid_r    <= 1'b0;
      newest_r    <= '0;
      oldest_r    <= '0;
      hit_r       <= 1'b0;
      ev_r        <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= MAX_ENTRIES_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
      if (cfg_valid && cfg_ready) max_r <= cfg_data;
      unique case (state_r)
        ST_SWEEP: begin
          sweep_r <= sweep_r + SW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            key_r   <= in_key;
            pay_r   <= in_fill_payload;
            act_r   <= in_action;
            h_r     <= key_hash(in_key);
            hit_r   <= 1'b0;
            res_r   <= '0;
            ev_r    <= 1'b0;
            sweep_r <= '0;
            clr_pend_r <= (in_action == ACT_CLEAR);
            if (in_action == ACT_CLEAR) begin
              held_r   <= '0;
              alloc_r  <= '0;
              fvalid_r <= 1'b0;
              newest_r <= '0;
              oldest_r <= '0;
            end
          end
        end
        ST_HEAD: begin
          cur_r <= head_rd[SW-1:0];
        end
        ST_CMP: begin
          if (match) begin
            if (act_r == ACT_LOOKUP) begin
              hit_r <= 1'b1;
              res_r <= key_rd[PAY_W-1:0];
            end
          end else begin
            cur_r <= hn_rd[SW-1:0];
          end
        end
        ST_MTF1: begin
          if (cur_r == oldest_r) oldest_r <= newer_rd;
        end
        ST_MTF2: begin
          newest_r <= cur_r;
        end
        ST_EV_CHK: begin
        end
        ST_EV_HASH: begin
          onext_r <= newer_rd;
          ohn_r   <= hn_rd;
          eh_r    <= key_hash(key_rd[WORD_W-1:PAY_W]);
        end
        ST_EV_HEAD: begin
          cur_r <= head_rd[SW-1:0];
        end
        ST_EV_WALK: begin
          if (hn_rd[SW-1:0] != oldest_r) cur_r <= hn_rd[SW-1:0];
        end
        ST_EV_FREE: begin
          fhead_r  <= oldest_r;
          fvalid_r <= 1'b1;
          oldest_r <= onext_r;
          held_r   <= held_r - CW'(1);
          ev_r     <= 1'b1;
        end
        ST_INS_WR: begin
          if (use_alloc) begin
            alloc_r <= alloc_r + CW'(1);
          end else begin
            fhead_r  <= hn_rd[SW-1:0];
            fvalid_r <= hn_rd[SW];
          end
          if (held_r == '0) oldest_r <= new_slot;
          newest_r <= new_slot;
          held_r   <= held_r + CW'(1);
        end
        ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  lrc_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .bump  (bump),
    .stats (stats)
  );

  // results come straight from the registers; nothing moves during the strobe
  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_result_payload = res_r;
  assign out_evicted        = ev_r;
  assign out_entry_count    = CNT_OUT_W'(held_r);
  assign out_hit_count      = stats.hit;
  assign out_miss_count     = stats.miss;
  assign out_eviction_count = stats.evict;
  assign out_failure_count  = stats.fail;

  // never more entries than slots handed out
  a_held_le_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r <= alloc_r) && (alloc_r <= CW'(CAPACITY)))
    else $error("entry count exceeds allocated slots");

  // a slot is always available at insertion
  a_slot_avail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_WR) |-> (use_alloc || fvalid_r))
    else $error("insertion with no free slot");

  // insertion only below the limit
  a_ins_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_WR) |-> (LW'(held_r) < lim))
    else $error("insertion at or above the entry limit");

  // the result strobe is one cycle wide
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  // accepting an item makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("not busy after accepting an item");

endmodule

// ===== test/lru_result_cache_tb.sv =====
// Testbench for lru_result_cache: directed and random lookups, fills and clears,
// checked against an LRU predictor.
`timescale 1ns / 100ps

module lru_result_cache_tb;
  import lrc_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [15:0] tx_x, tx_y, tx_z, rx_x, rx_y, rx_z;
    logic [39:0] carrier;
    logic [31:0] bucket;
    logic [63:0] digest;
  } cache_key_t;

  typedef struct {
    logic [1:0]  action;
    cache_key_t  key;
    logic        good;
    logic [63:0] payload;
  } cache_req_t;

  typedef struct {
    logic        hit;
    logic [63:0] payload;
    logic        evicted;
    logic [12:0] entries;
    logic [31:0] hits, misses, evictions, failures;
  } cache_resp_t;

  typedef struct {
    cache_key_t  key;
    logic [63:0] payload;
  } lru_entry_t;

  // LRU predictor plus queue of expected responses
  class lru_scoreboard;
    lru_entry_t  lru_q[$];      // front is the oldest entry
    cache_resp_t resp_q[$];
    logic [12:0] max_entries;
    logic [31:0] n_hit, n_miss, n_evict, n_fail;
    int          errors;
    int          n_checked;
    int          n_hits_seen, n_evicts_seen;

    function new();
      max_entries = MAX_ENTRIES_RST;
      n_hit = '0; n_miss = '0; n_evict = '0; n_fail = '0;
      errors = 0; n_checked = 0; n_hits_seen = 0; n_evicts_seen = 0;
    endfunction

    function logic [31:0] sat_add(logic [31:0] c, int n);
      logic [32:0] s;
      s = {1'b0, c} + 33'(n);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function int find_key(cache_key_t k);
      foreach (lru_q[i]) if (lru_q[i].key == k) return i;
      return -1;
    endfunction

    // predict the response to one accepted item
    function void note_item(cache_req_t r);
      cache_resp_t e;
      lru_entry_t  ent;
      int          idx, lim, n;
      e.hit = 1'b0; e.payload = '0; e.evicted = 1'b0;
      idx = -1;
      if (r.action == ACT_LOOKUP || r.action == ACT_FILL) idx = find_key(r.key);
      case (r.action)
        ACT_LOOKUP: begin
          if (idx >= 0) begin
            ent = lru_q[idx];
            lru_q.delete(idx);
            lru_q.push_back(ent);
            e.hit = 1'b1;
            e.payload = ent.payload;
            n_hit = sat_add(n_hit, 1);
          end else begin
            n_miss = sat_add(n_miss, 1);
          end
        end
        ACT_FILL: begin
          if (!r.good) begin
            n_fail = sat_add(n_fail, 1);
          end else if (idx >= 0) begin
            // refresh only
            ent = lru_q[idx];
            ent.payload = r.payload;
            lru_q.delete(idx);
            lru_q.push_back(ent);
          end else begin
            lim = (max_entries == 0) ? 1 : int'(max_entries);
            if (lim > CAP) lim = CAP;
            n = 0;
            while (lru_q.size() >= lim && lru_q.size() > 0) begin
              void'(lru_q.pop_front());
              n++;
            end
            if (n > 0) begin
              e.evicted = 1'b1;
              n_evict = sat_add(n_evict, n);
            end
            ent.key = r.key;
            ent.payload = r.payload;
            lru_q.push_back(ent);
          end
        end
        ACT_CLEAR: begin
          lru_q.delete();
          n_hit = '0; n_miss = '0; n_evict = '0; n_fail = '0;
        end
        default: ;
      endcase
      e.entries = 13'(lru_q.size());
      e.hits = n_hit; e.misses = n_miss; e.evictions = n_evict; e.failures = n_fail;
      resp_q.push_back(e);
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // compare one response with the oldest prediction
    function void check_resp(cache_resp_t a);
      cache_resp_t e;
      if (resp_q.size() == 0) begin
        $error("response with no item outstanding");
        errors++;
        return;
      end
      e = resp_q.pop_front();
      n_checked++;
      if (e.hit) n_hits_seen++;
      if (e.evicted) n_evicts_seen++;
      check_field("hit", 64'(e.hit), 64'(a.hit));
      check_field("result_payload", e.payload, a.payload);
      check_field("evicted", 64'(e.evicted), 64'(a.evicted));
      check_field("entry_count", 64'(e.entries), 64'(a.entries));
      check_field("hit_count", 64'(e.hits), 64'(a.hits));
      check_field("miss_count", 64'(e.misses), 64'(a.misses));
      check_field("eviction_count", 64'(e.evictions), 64'(a.evictions));
      check_field("failure_count", 64'(e.failures), 64'(a.failures));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [12:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic signed [15:0] in_tx_cell_x = '0, in_tx_cell_y = '0, in_tx_cell_z = '0;
  logic signed [15:0] in_rx_cell_x = '0, in_rx_cell_y = '0, in_rx_cell_z = '0;
  logic [39:0] in_carrier_hz = '0;
  logic [31:0] in_time_bucket = '0;
  logic [63:0] in_setup_digest = '0;
  logic in_fill_good = 1'b0;
  logic [63:0] in_fill_payload = '0;
  logic out_valid, out_hit, out_evicted;
  logic [63:0] out_result_payload;
  logic [12:0] out_entry_count;
  logic [31:0] out_hit_count, out_miss_count, out_eviction_count, out_failure_count;

  lru_scoreboard sb;
  cache_key_t key_pool[24];
  bit no_gaps;
  int n_items;

  always #4 clk = ~clk;

  lru_result_cache dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .in_action(in_action),
    .in_tx_cell_x(in_tx_cell_x), .in_tx_cell_y(in_tx_cell_y), .in_tx_cell_z(in_tx_cell_z),
    .in_rx_cell_x(in_rx_cell_x), .in_rx_cell_y(in_rx_cell_y), .in_rx_cell_z(in_rx_cell_z),
    .in_carrier_hz(in_carrier_hz), .in_time_bucket(in_time_bucket),
    .in_setup_digest(in_setup_digest), .in_fill_good(in_fill_good),
    .in_fill_payload(in_fill_payload),
    .out_valid(out_valid), .out_hit(out_hit), .out_result_payload(out_result_payload),
    .out_evicted(out_evicted), .out_entry_count(out_entry_count),
    .out_hit_count(out_hit_count), .out_miss_count(out_miss_count),
    .out_eviction_count(out_eviction_count), .out_failure_count(out_failure_count)
  );

  // response monitor
  always @(posedge clk) begin
    cache_resp_t r;
    if (rst_n && out_valid) begin
      r.hit = out_hit; r.payload = out_result_payload; r.evicted = out_evicted;
      r.entries = out_entry_count;
      r.hits = out_hit_count; r.misses = out_miss_count;
      r.evictions = out_eviction_count; r.failures = out_failure_count;
      sb.check_resp(r);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic cache_key_t rand_key();
    cache_key_t k;
    k.tx_x = 16'($urandom); k.tx_y = 16'($urandom); k.tx_z = 16'($urandom);
    k.rx_x = 16'($urandom); k.rx_y = 16'($urandom); k.rx_z = 16'($urandom);
    k.carrier = 40'({$urandom, $urandom});
    k.bucket = $urandom;
    k.digest = {$urandom, $urandom};
    return k;
  endfunction

  function automatic cache_key_t fill_key(logic b);
    cache_key_t k;
    k = {$bits(cache_key_t){b}};
    return k;
  endfunction

  // drive one item and hold it until accepted
  task automatic send_item(logic [1:0] act, cache_key_t k, logic good, logic [63:0] pay);
    cache_req_t r;
    int g;
    start <= 1'b1;
    in_action <= act;
    in_tx_cell_x <= k.tx_x; in_tx_cell_y <= k.tx_y; in_tx_cell_z <= k.tx_z;
    in_rx_cell_x <= k.rx_x; in_rx_cell_y <= k.rx_y; in_rx_cell_z <= k.rx_z;
    in_carrier_hz <= k.carrier; in_time_bucket <= k.bucket; in_setup_digest <= k.digest;
    in_fill_good <= good; in_fill_payload <= pay;
    do @(posedge clk); while (busy);
    r.action = act; r.key = k; r.good = good; r.payload = pay;
    sb.note_item(r);
    n_items++;
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // drain all responses, then let the block settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while ((sb.resp_q.size() != 0 || busy) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.resp_q.size() != 0) begin
      $error("%0d responses never arrived", sb.resp_q.size());
      sb.errors++;
      sb.resp_q.delete();
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [12:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.max_entries = v;
    @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [1:0] act;
    cache_key_t k;
    r = $urandom_range(0, 99);
    if (r < 48) act = ACT_LOOKUP;
    else if (r < 94) act = ACT_FILL;
    else if (r < 96) act = ACT_CLEAR;
    else act = ACT_UNUSED;
    k = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, 23)] : rand_key();
    send_item(act, k, $urandom_range(0, 99) < 85, {$urandom, $urandom});
  endtask

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    cache_key_t kmin, kmax, kzero;
    logic [12:0] limits[7];
    sb = new();
    n_items = 0;
    no_gaps = 1'b0;
    limits = '{13'd3, 13'd1, 13'd0, 13'd8191, 13'd2, 13'd6, 13'd4096};
    kmin = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
             40'd0, 32'd0, 64'd0};
    kmax = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
             {40{1'b1}}, {32{1'b1}}, {64{1'b1}}};
    kzero = fill_key(1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // reset sweep keeps busy high for a while
    do @(posedge clk); while (busy);

    // directed: extremes, refresh, failed fill, unused code, clear
    send_item(ACT_LOOKUP, kmax, 1'b0, 64'd0);
    send_item(ACT_FILL, kmax, 1'b1, {64{1'b1}});
    send_item(ACT_LOOKUP, kmax, 1'b0, 64'd0);
    send_item(ACT_FILL, kmin, 1'b1, 64'd0);
    send_item(ACT_FILL, kzero, 1'b1, 64'h0123_4567_89AB_CDEF);
    send_item(ACT_FILL, kmax, 1'b1, 64'hA5A5_5A5A_F00F_0FF0);
    send_item(ACT_FILL, kmin, 1'b0, {64{1'b1}});
    send_item(ACT_LOOKUP, kmin, 1'b0, 64'd0);
    send_item(ACT_LOOKUP, kmax, 1'b1, {64{1'b1}});
    send_item(ACT_UNUSED, kmax, 1'b1, {64{1'b1}});
    send_item(ACT_CLEAR, kmin, 1'b0, 64'd0);
    send_item(ACT_LOOKUP, kmax, 1'b0, 64'd0);
    // limit of one: the second new fill evicts the first
    write_limit(13'd1);
    send_item(ACT_FILL, kmin, 1'b1, 64'd5);
    send_item(ACT_FILL, kmax, 1'b1, 64'd6);
    send_item(ACT_LOOKUP, kmin, 1'b0, 64'd0);
    // zero limit acts as one
    write_limit(13'd0);
    send_item(ACT_FILL, kzero, 1'b1, 64'd7);
    send_item(ACT_LOOKUP, kmax, 1'b0, 64'd0);
    // lowered limit evicts several at once
    write_limit(13'd8191);
    send_item(ACT_FILL, kmin, 1'b1, 64'd8);
    send_item(ACT_FILL, kmax, 1'b1, 64'd9);
    write_limit(13'd1);
    send_item(ACT_FILL, fill_key(1'b1) ^ kmax ^ 232'd1, 1'b1, 64'd10);
    send_item(ACT_LOOKUP, kzero, 1'b0, 64'd0);

    // random phases, one limit per phase
    foreach (limits[p]) begin
      write_limit(limits[p]);
      foreach (key_pool[i]) key_pool[i] = rand_key();
      no_gaps = (p % 3 == 1);
      repeat (100) random_item();
    end

    wait_idle();
    $display("Ran %0d items, %0d responses checked: %0d hits, %0d evicting fills.",
             n_items, sb.n_checked, sb.n_hits_seen, sb.n_evicts_seen);
    $display("Limits covered: 0, 1, 2, 3, 6, 4096 and 8191, with clears and refresh fills.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
